[hw/rtl/heat_diffusion_stencil_engine_assert.svh]
// ----------------------------------------------------------------------------
// heat diffusion stencil engine assertion macros
// shared property wrappers for the rtl assertions
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_ENGINE_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_ENGINE_ASSERT_SVH

// same-cycle implication
`define HDE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hde assertion failed");

// next-cycle implication
`define HDE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hde assertion failed");

`endif

[hw/rtl/hde_pkg.sv]
// ----------------------------------------------------------------------------
// hde_pkg
// shared types and constants of the heat diffusion stencil engine
// ----------------------------------------------------------------------------
package hde_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELLS      = MAX_ROWS * MAX_COLS;
    localparam int VAL_W      = 40;
    localparam int MAD_W      = 39;
    localparam int GAIN_W     = 17;
    localparam int ITER_W     = 20;
    localparam int SIZE_W     = 7;
    localparam int CNT_W      = 13;
    localparam int DIV_W      = 54;
    localparam int DIV_CNT_W  = 6;
    localparam int GAIN_ONE   = 65536;
    localparam int GAIN_SHIFT = 18;

    // signed 40-bit value limits at the width of the update sum
    localparam logic signed [43:0] SAT_MAX = 44'sh007FFFFFFFFF;
    localparam logic signed [43:0] SAT_MIN = -44'sh008000000000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ITERATIONS = 2'd0,
        REG_GAIN       = 2'd1,
        REG_ROWS       = 2'd2,
        REG_COLS       = 2'd3
    } t_reg_index;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SW_RD, S_SW_LAST, S_SW_MUL, S_SW_WR,
        S_SUM_RD, S_SUM_LAST, S_AVG_GO, S_AVG_WAIT,
        S_DEV_RD, S_DEV_LAST, S_DEV_GO, S_DEV_WAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic [GAIN_W-1:0] gain;
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] raddr;
        logic              we0;
        logic              we1;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

endpackage

[hw/rtl/heat_diffusion_stencil_engine.sv]
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_engine
// five-point jacobi heat diffusion over two ping-pong grid banks
// ----------------------------------------------------------------------------
// usage
//   slave channel: tuser carries the opcode, tdata the cell position and value.
//   write cell stores the item in the current bank.
//   clear grid zeroes both banks, one entry per cycle.
//   run performs the configured sweeps, then reports average and mean
//   absolute deviation as one item on the master channel.
//   a sweep handles each active cell in turn: 5 taps through the single read
//   port, drain, multiply, write back.
//   the block takes one item at a time and is ready only when idle.
//   after reset a clearing pass over all 4096 entries runs before the first item.
//   the result sits in an output register; a stalled master side holds it,
//   and a following run waits only at its report if that register is full.
//   configuration writes are taken at any edge with the write enable high.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cell_row [5:0], cell_col [11:6], cell_value [51:12], zero fill
    input  logic [55:0] i_s_tdata,
    // opcode [1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // average [39:0], mean_abs_deviation [78:40], zero fill
    output logic [79:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_wdata
);
    import hde_pkg::*;

    t_cfg                    r_cfg;
    t_mem_req                mem;
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic [VAL_W-1:0]        rd0, rd1;
    logic signed [VAL_W-1:0] average;
    logic [MAD_W-1:0]        mad;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iterations <= '0;
            r_cfg.gain       <= '0;
            r_cfg.rows       <= SIZE_W'(MAX_ROWS);
            r_cfg.cols       <= SIZE_W'(MAX_COLS);
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_addr))
                REG_ITERATIONS: r_cfg.iterations <= i_cfg_wdata;
                REG_GAIN:       r_cfg.gain       <= i_cfg_wdata[GAIN_W-1:0];
                REG_ROWS:       r_cfg.rows       <= i_cfg_wdata[SIZE_W-1:0];
                REG_COLS:       r_cfg.cols       <= i_cfg_wdata[SIZE_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // sequencer
    hde_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_opcode     (i_s_tuser),
        .i_cell_row   (i_s_tdata[5:0]),
        .i_cell_col   (i_s_tdata[11:6]),
        .i_cell_value (i_s_tdata[51:12]),
        .i_cfg        (r_cfg),
        .o_mem        (mem),
        .i_rd0        (rd0),
        .i_rd1        (rd1),
        .o_div        (div_req),
        .i_div        (div_rsp),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_average    (average),
        .o_mad        (mad)
    );

    // shared divider
    hde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // grid banks
    hde_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (mem.we0),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rd0)
    );

    hde_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (mem.we1),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rd1)
    );

    assign o_m_tdata = {1'b0, mad, average};

endmodule

[hw/rtl/hde_ram.sv]
// ----------------------------------------------------------------------------
// hde_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module hde_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/hde_div.sv]
// ----------------------------------------------------------------------------
// hde_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hde_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hde_pkg::t_div_req i_req,
    output hde_pkg::t_div_rsp o_rsp
);
    import hde_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_quo;
    logic [CNT_W:0]       rem_sh;
    logic                 ge;

    // trial subtract
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= ge ? CNT_W'(rem_sh - {1'b0, r_den}) : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[hw/rtl/hde_ctrl.sv]
// ----------------------------------------------------------------------------
// hde_ctrl
// sequencer and datapath: load, clear, stencil sweeps and report passes
// ----------------------------------------------------------------------------
`include "heat_diffusion_stencil_engine_assert.svh"

module hde_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [hde_pkg::ROW_W-1:0]           i_cell_row,
    input  logic [hde_pkg::COL_W-1:0]           i_cell_col,
    input  logic signed [hde_pkg::VAL_W-1:0]    i_cell_value,
    input  hde_pkg::t_cfg                       i_cfg,
    output hde_pkg::t_mem_req                   o_mem,
    input  logic [hde_pkg::VAL_W-1:0]           i_rd0,
    input  logic [hde_pkg::VAL_W-1:0]           i_rd1,
    output hde_pkg::t_div_req                   o_div,
    input  hde_pkg::t_div_rsp                   i_div,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hde_pkg::VAL_W-1:0]    o_average,
    output logic [hde_pkg::MAD_W-1:0]           o_mad
);
    import hde_pkg::*;

    t_state r_state, n_state;

    logic                     r_front;
    logic [ADDR_W-1:0]        r_clr;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic [2:0]               r_k;
    logic                     r_pend;
    logic [2:0]               r_pk;
    logic                     r_pm;
    logic signed [VAL_W-1:0]  r_v;
    logic signed [41:0]       r_s;
    logic signed [60:0]       r_p;
    logic [ITER_W-1:0]        r_iter;
    logic signed [51:0]       r_sum;
    logic                     r_neg;
    logic signed [VAL_W-1:0]  r_avg;
    logic [52:0]              r_dev;
    logic [MAD_W-1:0]         r_mad;
    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_avg;
    logic [MAD_W-1:0]         r_out_mad;

    logic [SIZE_W-1:0]        rows_c, cols_c;
    logic [ROW_W-1:0]         rows_m1;
    logic [COL_W-1:0]         cols_m1;
    logic [CNT_W-1:0]         cells_n;
    logic [GAIN_W-1:0]        gain_c;
    logic                     last_cell;
    logic                     last_iter;
    logic                     accept;
    logic                     out_load;
    logic [ADDR_W-1:0]        nb_addr;
    logic                     nb_mask;
    logic signed [VAL_W-1:0]  g;
    logic signed [42:0]       d;
    logic signed [60:0]       prod;
    logic signed [60:0]       rnd;
    logic signed [42:0]       t_inc;
    logic signed [43:0]       nv;
    logic signed [VAL_W-1:0]  nv_sat;
    logic signed [40:0]       diff;
    logic [40:0]              diff_abs;
    logic [51:0]              sum_mag;
    logic [VAL_W-1:0]         q_lo;

    // clamped sizes and gain
    always_comb begin
        if (i_cfg.rows == '0) rows_c = SIZE_W'(1);
        else if (i_cfg.rows > SIZE_W'(MAX_ROWS)) rows_c = SIZE_W'(MAX_ROWS);
        else rows_c = i_cfg.rows;
        if (i_cfg.cols == '0) cols_c = SIZE_W'(1);
        else if (i_cfg.cols > SIZE_W'(MAX_COLS)) cols_c = SIZE_W'(MAX_COLS);
        else cols_c = i_cfg.cols;
        gain_c = (i_cfg.gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : i_cfg.gain;
    end

    assign rows_m1   = ROW_W'(rows_c - 1'b1);
    assign cols_m1   = COL_W'(cols_c - 1'b1);
    assign cells_n   = CNT_W'(rows_c * cols_c);
    assign last_cell = (r_row == rows_m1) && (r_col == cols_m1);
    assign last_iter = ({1'b0, r_iter} + 1'b1) == {1'b0, i_cfg.iterations};
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // stencil tap address and in-grid mask
    always_comb begin
        unique case (r_k)
            3'd0: begin nb_addr = {r_row, r_col};                 nb_mask = 1'b1;              end
            3'd1: begin nb_addr = {r_row, COL_W'(r_col - 1'b1)};  nb_mask = (r_col != '0);     end
            3'd2: begin nb_addr = {r_row, COL_W'(r_col + 1'b1)};  nb_mask = (r_col != cols_m1); end
            3'd3: begin nb_addr = {ROW_W'(r_row - 1'b1), r_col};  nb_mask = (r_row != '0);     end
            3'd4: begin nb_addr = {ROW_W'(r_row + 1'b1), r_col};  nb_mask = (r_row != rows_m1); end
            default: begin nb_addr = {r_row, r_col};              nb_mask = 1'b0;              end
        endcase
    end

    // arithmetic
    assign g        = r_front ? i_rd1 : i_rd0;
    assign d        = {r_s[41], r_s} - {r_v[VAL_W-1], r_v, 2'b00};
    assign prod     = d * $signed({1'b0, gain_c});
    assign rnd      = (r_p + 61'sd131072) >>> GAIN_SHIFT;
    assign t_inc    = rnd[42:0];
    assign nv       = {{4{r_v[VAL_W-1]}}, r_v} + {t_inc[42], t_inc};
    assign nv_sat   = (nv > SAT_MAX) ? SAT_MAX[VAL_W-1:0] :
                      (nv < SAT_MIN) ? SAT_MIN[VAL_W-1:0] : nv[VAL_W-1:0];
    assign diff     = {g[VAL_W-1], g} - {r_avg[VAL_W-1], r_avg};
    assign diff_abs = diff[40] ? 41'(-diff) : 41'(diff);
    assign sum_mag  = r_sum[51] ? 52'(-r_sum) : 52'(r_sum);
    assign q_lo     = i_div.quotient[VAL_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:      if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid && i_opcode == OP_RUN) begin
                    n_state = (gain_c == '0 || i_cfg.iterations == '0) ? S_SUM_RD : S_SW_RD;
                end else if (i_in_valid && i_opcode == OP_CLEAR) begin
                    n_state = S_CLR;
                end
            end
            S_SW_RD:    if (r_k == 3'd4) n_state = S_SW_LAST;
            S_SW_LAST:  n_state = S_SW_MUL;
            S_SW_MUL:   n_state = S_SW_WR;
            S_SW_WR:    n_state = (last_cell && last_iter) ? S_SUM_RD : S_SW_RD;
            S_SUM_RD:   if (last_cell) n_state = S_SUM_LAST;
            S_SUM_LAST: n_state = S_AVG_GO;
            S_AVG_GO:   n_state = S_AVG_WAIT;
            S_AVG_WAIT: if (i_div.done) n_state = S_DEV_RD;
            S_DEV_RD:   if (last_cell) n_state = S_DEV_LAST;
            S_DEV_LAST: n_state = S_DEV_GO;
            S_DEV_GO:   n_state = S_DEV_WAIT;
            S_DEV_WAIT: if (i_div.done) n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory and divider requests
    always_comb begin
        o_mem        = '0;
        o_div        = '0;
        o_div.divisor = cells_n;
        o_in_ready   = (r_state == S_IDLE);
        unique case (r_state)
            S_CLR: begin
                o_mem.we0   = 1'b1;
                o_mem.we1   = 1'b1;
                o_mem.waddr = r_clr;
            end
            S_IDLE: begin
                if (accept && i_opcode == OP_WRITE) begin
                    o_mem.we0   = !r_front;
                    o_mem.we1   = r_front;
                    o_mem.waddr = {i_cell_row, i_cell_col};
                    o_mem.wdata = i_cell_value;
                end
            end
            S_SW_RD:  o_mem.raddr = nb_addr;
            S_SW_WR: begin
                o_mem.we0   = r_front;
                o_mem.we1   = !r_front;
                o_mem.waddr = {r_row, r_col};
                o_mem.wdata = nv_sat;
            end
            S_SUM_RD, S_DEV_RD: o_mem.raddr = {r_row, r_col};
            S_AVG_GO: begin
                o_div.start    = 1'b1;
                o_div.dividend = {2'b00, sum_mag};
            end
            S_DEV_GO: begin
                o_div.start    = 1'b1;
                o_div.dividend = {1'b0, r_dev};
            end
            default: o_mem.raddr = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_front     <= 1'b0;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_k         <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SW_RD) || (r_state == S_SUM_RD) ||
                       (r_state == S_DEV_RD);
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (r_state == S_SW_RD) r_k <= (r_k == 3'd4) ? 3'd0 : r_k + 1'b1;
            // cell walk
            if (accept) begin
                r_row  <= '0;
                r_col  <= '0;
                r_iter <= '0;
                r_k    <= '0;
            end else if (r_state == S_SW_WR || r_state == S_SUM_RD ||
                         r_state == S_DEV_RD) begin
                if (last_cell) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (r_col == cols_m1) begin
                    r_row <= r_row + 1'b1;
                    r_col <= '0;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            // bank swap at sweep end
            if (r_state == S_SW_WR && last_cell) begin
                r_front <= !r_front;
                r_iter  <= r_iter + 1'b1;
            end
            // output register
            if (out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pk <= r_k;
        r_pm <= nb_mask;
        if (accept || r_state == S_SW_WR) r_s <= '0;
        if (accept) begin
            r_sum <= '0;
            r_dev <= '0;
        end
        if (r_pend) begin
            unique case (r_state)
                S_SW_RD, S_SW_LAST: begin
                    if (r_pk == 3'd0) r_v <= g;
                    else if (r_pm) r_s <= r_s + {{2{g[VAL_W-1]}}, g};
                end
                S_SUM_RD, S_SUM_LAST: r_sum <= r_sum + {{12{g[VAL_W-1]}}, g};
                S_DEV_RD, S_DEV_LAST: r_dev <= r_dev + {12'b0, diff_abs};
                default: r_sum <= r_sum;
            endcase
        end
        if (r_state == S_SW_MUL) r_p <= prod;
        if (r_state == S_AVG_GO) r_neg <= r_sum[51];
        if (r_state == S_AVG_WAIT && i_div.done) r_avg <= r_neg ? VAL_W'(-q_lo) : q_lo;
        if (r_state == S_DEV_WAIT && i_div.done) begin
            r_mad <= (i_div.quotient > DIV_W'(SAT_MAX)) ? '1 : i_div.quotient[MAD_W-1:0];
        end
        if (out_load) begin
            r_out_avg <= r_avg;
            r_out_mad <= r_mad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_out_avg;
    assign o_mad       = r_out_mad;

    // checks
    `HDE_ASSERT_IMP(a_dual_write_only_clear, i_clk, i_rst_n,
        o_mem.we0 && o_mem.we1, r_state == S_CLR)
    `HDE_ASSERT_IMP(a_sweep_writes_back_bank, i_clk, i_rst_n,
        r_state == S_SW_WR, (o_mem.we0 == r_front) && (o_mem.we1 != r_front))
    `HDE_ASSERT_IMP(a_taps_drained_before_mul, i_clk, i_rst_n,
        r_state == S_SW_MUL, !r_pend)
    `HDE_ASSERT_NXT(a_div_start_then_wait, i_clk, i_rst_n,
        o_div.start, r_state == S_AVG_WAIT || r_state == S_DEV_WAIT)

endmodule

[sim/heat_diffusion_stencil_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_engine_tb
// drives cell loads, clears and sweep runs with random gaps on both streams,
// predicts each report with a software jacobi model and checks it field by field
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_engine_tb;
    import hde_pkg::*;

    localparam longint VMAX = (64'sd1 <<< 39) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam int LIMIT_CYCLES = 20000000;

    typedef struct {
        logic [VAL_W-1:0] avg;
        logic [MAD_W-1:0] mad;
    } t_report;

    // ------------------------------------------------------------------------
    // grid predictor and report store
    // ------------------------------------------------------------------------
    class diffusion_scoreboard;
        longint bank0[CELLS];
        longint bank1[CELLS];
        bit     sel;
        int     iters, gain, rows, cols;
        t_report reports[$];
        int     mismatches, stray, checked;

        function new();
            foreach (bank0[k]) begin
                bank0[k] = 0;
                bank1[k] = 0;
            end
            sel = 0; iters = 0; gain = 0; rows = 64; cols = 64;
        endfunction

        function void set_reg(t_reg_index idx, int val);
            case (idx)
                REG_ITERATIONS: iters = val & 20'hfffff;
                REG_GAIN:       gain  = val & 17'h1ffff;
                REG_ROWS:       rows  = val & 7'h7f;
                REG_COLS:       cols  = val & 7'h7f;
            endcase
        endfunction

        // note one accepted item, run the sweeps for a run command
        function void note_item(t_opcode op, int row, int col, logic signed [VAL_W-1:0] val);
            int     nr, nc, g, at;
            longint v, s, d, p, sum, avg, dev, mad, n;
            longint nxt[CELLS];
            t_report rep;
            if (op == OP_WRITE) begin
                if (sel) bank1[row*MAX_COLS+col] = longint'(val);
                else     bank0[row*MAX_COLS+col] = longint'(val);
                return;
            end
            if (op == OP_CLEAR) begin
                foreach (bank0[k]) begin
                    bank0[k] = 0;
                    bank1[k] = 0;
                end
                return;
            end
            if (op != OP_RUN) return;
            nr = rows < 1 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
            nc = cols < 1 ? 1 : (cols > MAX_COLS ? MAX_COLS : cols);
            g  = gain > GAIN_ONE ? GAIN_ONE : gain;
            // ping-pong sweeps, cells outside the active area keep their bank
            if (g != 0) begin
                for (int it = 0; it < iters; it++) begin
                    if (sel) nxt = bank0;
                    else     nxt = bank1;
                    for (int r = 0; r < nr; r++) begin
                        for (int c = 0; c < nc; c++) begin
                            at = r*MAX_COLS + c;
                            v = sel ? bank1[at] : bank0[at];
                            s = 0;
                            if (c > 0)      s += sel ? bank1[at-1] : bank0[at-1];
                            if (c+1 < nc)   s += sel ? bank1[at+1] : bank0[at+1];
                            if (r > 0)      s += sel ? bank1[at-MAX_COLS] : bank0[at-MAX_COLS];
                            if (r+1 < nr)   s += sel ? bank1[at+MAX_COLS] : bank0[at+MAX_COLS];
                            d = s - 4*v;
                            p = d * longint'(g) + (64'sd1 <<< (GAIN_SHIFT-1));
                            v = v + (p >>> GAIN_SHIFT);
                            nxt[at] = v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
                        end
                    end
                    if (sel) bank0 = nxt;
                    else     bank1 = nxt;
                    sel = ~sel;
                end
            end
            // average and mean absolute deviation, truncated
            n = nr * nc;
            sum = 0;
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    sum += sel ? bank1[r*MAX_COLS+c] : bank0[r*MAX_COLS+c];
            avg = sum / n;
            dev = 0;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    d = (sel ? bank1[r*MAX_COLS+c] : bank0[r*MAX_COLS+c]) - avg;
                    dev += d < 0 ? -d : d;
                end
            end
            mad = dev / n;
            if (mad > VMAX) mad = VMAX;
            rep.avg = avg[VAL_W-1:0];
            rep.mad = mad[MAD_W-1:0];
            reports.push_back(rep);
        endfunction

        function void check_report(logic [VAL_W-1:0] avg, logic [MAD_W-1:0] mad);
            t_report exp_rep;
            if (reports.size() == 0) begin
                stray++;
                if (stray + mismatches <= 10)
                    $display("unexpected report avg=%h mad=%h", avg, mad);
                return;
            end
            exp_rep = reports.pop_front();
            checked++;
            if (exp_rep.avg !== avg || exp_rep.mad !== mad) begin
                mismatches++;
                if (mismatches + stray <= 10)
                    $display("report mismatch: avg exp %h got %h, mad exp %h got %h",
                             exp_rep.avg, avg, exp_rep.mad, mad);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;   // cell_row, cell_col, cell_value, zero fill
    logic [1:0]  i_s_tuser = '0;   // opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;        // average, mean_abs_deviation, zero fill
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [19:0] i_cfg_wdata = '0;

    diffusion_scoreboard grid_sb = new();
    int hold_cycles = 0;
    int sent = 0, runs_sent = 0;
    longint cycles = 0;

    heat_diffusion_stencil_engine dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    // result side: random stalls plus an optional long hold-off
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                grid_sb.check_report(o_m_tdata[39:0], o_m_tdata[78:40]);
                stall = draw_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("heat_diffusion_stencil_engine_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(t_opcode op, int row, int col, logic [VAL_W-1:0] val, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, val, col[5:0], row[5:0]};
        do @(posedge i_clk); while (!o_s_tready);
        grid_sb.note_item(op, row, col, val);
        sent++;
        if (op == OP_RUN) runs_sent++;
    endtask

    // wait until all reports are back and the block has finished any clear
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (grid_sb.reports.size() != 0) @(posedge i_clk);
        repeat (4200) @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic load_config(int iters, int gain, int rows, int cols);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= REG_ITERATIONS; i_cfg_wdata <= 20'(iters);
        grid_sb.set_reg(REG_ITERATIONS, iters);
        @(negedge i_clk);
        i_cfg_addr <= REG_GAIN; i_cfg_wdata <= 20'(gain);
        grid_sb.set_reg(REG_GAIN, gain);
        @(negedge i_clk);
        i_cfg_addr <= REG_ROWS; i_cfg_wdata <= 20'(rows);
        grid_sb.set_reg(REG_ROWS, rows);
        @(negedge i_clk);
        i_cfg_addr <= REG_COLS; i_cfg_wdata <= 20'(cols);
        grid_sb.set_reg(REG_COLS, cols);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] draw_value();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return w[39:0];
            1:       return 40'h7f_ffff_ffff;
            2:       return 40'h80_0000_0000;
            default: return {{19{w[20]}}, w[20:0]};
        endcase
    endfunction

    initial begin
        int rows, cols, nr, nc, iters, gain, k;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset grid, extremes, ignored opcode
        send_item(OP_RUN, 0, 0, '0, 0);
        send_item(OP_WRITE, 0, 0, 40'h7f_ffff_ffff, 0);
        send_item(OP_WRITE, 63, 63, 40'h80_0000_0000, 0);
        send_item(OP_WRITE, 0, 63, 40'h80_0000_0000, 0);
        send_item(t_opcode'(2'd3), 63, 0, 40'hff_ffff_ffff, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        drain();
        // full gain with saturating extremes on a small grid, gain above one
        load_config(3, 131071, 3, 4);
        send_item(OP_WRITE, 1, 1, 40'h7f_ffff_ffff, 0);
        send_item(OP_WRITE, 0, 0, 40'h80_0000_0000, 0);
        send_item(OP_WRITE, 2, 3, 40'h7f_ffff_ffff, 0);
        send_item(OP_WRITE, 5, 5, 40'h12_3456_789a, 0);
        send_item(OP_RUN, 0, 0, '0, 2);
        drain();
        // out-of-range sizes saturate, zero gain with max iterations
        load_config(20'hfffff, 0, 0, 127);
        send_item(OP_RUN, 0, 0, '0, 0);
        drain();
        load_config(1, 65536, 1, 64);
        send_item(OP_RUN, 0, 0, '0, 0);
        send_item(OP_CLEAR, 0, 0, '0, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        drain();
        // one full-size sweep
        load_config(1, 32768, 64, 64);
        send_item(OP_WRITE, 31, 31, 40'h00_0100_0000, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        drain();

        // long result hold-off: block fills its report register and stalls
        load_config(2, 40000, 3, 3);
        hold_cycles = 3000;
        send_item(OP_WRITE, 1, 1, 40'h00_0010_0000, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        send_item(OP_WRITE, 2, 2, 40'hff_fff0_0000, 0);
        send_item(OP_RUN, 0, 0, '0, 0);
        drain();

        // random phases
        while (sent < 1900) begin
            rows  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            cols  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            nr    = rows < 1 ? 1 : (rows > 64 ? 64 : rows);
            nc    = cols < 1 ? 1 : (cols > 64 ? 64 : cols);
            gain  = $urandom_range(0, 131071);
            iters = $urandom_range(0, 4);
            // big grids only without sweeps, where any iteration count is cheap
            if (nr * nc > 64) begin
                gain  = 0;
                iters = $urandom_range(0, 20'hfffff);
            end
            load_config(iters, gain, rows, cols);
            for (int j = 0; j < 150 && sent < 1900; j++) begin
                k = $urandom_range(0, 99);
                if (k < 82)
                    send_item(OP_WRITE, $urandom_range(0, nr-1), $urandom_range(0, nc-1),
                              draw_value(), draw_gap());
                else if (k < 93)
                    send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                              draw_value(), draw_gap());
                else if (k < 94)
                    send_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                              draw_value(), draw_gap());
                else if (k < 98)
                    send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                              40'({$urandom, $urandom}), draw_gap());
                else
                    send_item(t_opcode'(2'd3), $urandom_range(0, 63), $urandom_range(0, 63),
                              40'({$urandom, $urandom}), draw_gap());
            end
            drain();
        end

        $display("sent %0d items including %0d run commands; %0d reports checked",
                 sent, runs_sent, grid_sb.checked);
        $display("%0d mismatches, %0d unexpected reports", grid_sb.mismatches, grid_sb.stray);
        if (grid_sb.mismatches == 0 && grid_sb.stray == 0 && grid_sb.reports.size() == 0)
            $display("heat_diffusion_stencil_engine_tb OK");
        else
            $display("heat_diffusion_stencil_engine_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hde_pkg.sv
hw/rtl/hde_ram.sv
hw/rtl/hde_div.sv
hw/rtl/hde_ctrl.sv
hw/rtl/heat_diffusion_stencil_engine.sv
sim/heat_diffusion_stencil_engine_tb.sv
